// ===== src/dpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dpt_pkg;

    localparam logic [2:0] REG_WARN_QUANTITY = 3'd0;
    localparam logic [2:0] REG_WARN_ABOVE = 3'd1;
    localparam logic [2:0] REG_WARN_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_ANTOINE_A = 3'd3;
    localparam logic [2:0] REG_ANTOINE_B = 3'd4;
    localparam logic [2:0] REG_ANTOINE_C = 3'd5;

    localparam logic [1:0] QTY_TEMP = 2'd0;
    localparam logic [1:0] QTY_HUMIDITY = 2'd1;
    localparam logic [1:0] QTY_PRESSURE = 2'd2;
    localparam logic [1:0] QTY_DEW = 2'd3;

    localparam int DIV_STEPS = 48;
    localparam int EXP_STEPS = 30;
    localparam int LOG_STEPS = 30;

    typedef struct packed {
        logic [1:0]         qty;
        logic [55:0]        tprod;
        logic signed [24:0] rh;
        logic signed [24:0] t;
        logic               dinv;
        logic               dneg;
        logic               den0;
        logic [47:0]        pq;
        logic [49:0]        rem;
        logic [49:0]        dvs;
        logic signed [48:0] q;
        logic signed [23:0] e;
        logic signed [55:0] y;
        logic signed [9:0]  n;
        logic [29:0]        ef;
        logic [31:0]        acc;
        logic signed [31:0] pp;
        logic [4:0]         lp;
        logic [31:0]        lm;
        logic [29:0]        lf;
        logic signed [63:0] lprod;
        logic signed [21:0] logv;
        logic signed [50:0] den;
        logic signed [49:0] t2;
        logic signed [31:0] value;
        logic               inv;
    } item_t;

    typedef logic [31:0] root_tab_t [EXP_STEPS];

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] xr;
        r = 64'd0;
        b = 64'd1 << 62;
        xr = x;
        for (int i = 0; i < 32; i++)
        begin
            if (xr >= r + b)
            begin
                xr = xr - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic root_tab_t exp_root_table();
        root_tab_t tab;
        logic [63:0] t;
        t = 64'd1 << 31;
        for (int k = 0; k < EXP_STEPS; k++)
        begin
            t = isqrt64(t << 30);
            tab[k] = t[31:0];
        end
        return tab;
    endfunction

    localparam root_tab_t EXP_ROOT = exp_root_table();

endpackage

`default_nettype wire

// ===== src/humidity_sensor_dew_point_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Dew point unit: each item carries a raw temperature code, a raw humidity code and a
// quantity selector, and yields one result with the selected quantity (temperature,
// relative humidity, saturation pressure or dew point, signed Q16.16, saturated) plus
// alarm and invalid flags. One item is accepted per clock cycle, yet the pipeline halts
// while a result at the output is not taken. Items pass two 48-cell restoring dividers and
// the 30-cell exponent and logarithm chains. The user must write registers through the
// APB port only while no item is in flight; the block itself does not enforce this.

module humidity_sensor_dew_point_top
    import dpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // raw_temp, raw_humidity
    input  logic [1:0]  s_axis_tuser,   // quantity
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value
    output logic [1:0]  m_axis_tuser,   // alarm, invalid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [39:0] K_TGAIN = 40'd754711653253;
    localparam logic signed [63:0] T_BIAS = 64'sd2147483648 - (64'sd201219217818 <<< 16);
    localparam logic [31:0] K_LOG2_10 = 32'd3566893132;
    localparam logic signed [27:0] K_LOG10_2 = 28'sd80807124;
    localparam logic signed [50:0] E_LIM = 51'sd4194304;
    localparam logic signed [31:0] V_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] V_MIN = 32'sh8000_0000;

    logic [2:0]  warn_quantity_reg;
    logic        warn_above_reg;
    logic signed [31:0] warn_threshold_reg;
    logic [31:0] antoine_a_reg;
    logic [31:0] antoine_b_reg;
    logic [31:0] antoine_c_reg;

    logic        en;
    item_t       stg_reg [15];
    item_t       stg_next [15];
    logic [14:0] stg_vld_reg;
    logic [14:0] stg_vin;

    item_t       d1_item [DIV_STEPS + 1];
    logic [DIV_STEPS:0] d1_vld;
    item_t       d2_item [DIV_STEPS + 1];
    logic [DIV_STEPS:0] d2_vld;
    item_t       ex_item [EXP_STEPS + 1];
    logic [EXP_STEPS:0] ex_vld;
    item_t       lg_item [LOG_STEPS + 1];
    logic [LOG_STEPS:0] lg_vld;

    logic        out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic        out_alarm_reg;
    logic        out_inv_reg;
    logic        alarm_next;

    logic [15:0] st_c;
    logic [15:0] sh_c;
    logic signed [63:0] tsum;
    logic signed [33:0] dsum;
    logic signed [33:0] dmag;
    logic signed [50:0] ediff;
    logic signed [56:0] ywide;
    logic signed [10:0] sexp;
    logic [5:0]  rsh;
    logic [33:0] lsh;
    logic [40:0] rsum;
    logic signed [35:0] l2;
    logic signed [63:0] lsum;
    logic signed [50:0] dmag2;
    logic signed [50:0] ndew;

    assign en = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign pready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_quantity_reg <= 3'd0;
            warn_above_reg <= 1'b0;
            warn_threshold_reg <= 32'sd0;
            antoine_a_reg <= 32'd533017;
            antoine_b_reg <= 32'd115499991;
            antoine_c_reg <= 32'd15444214;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                REG_WARN_QUANTITY:  warn_quantity_reg <= pwdata[2:0];
                REG_WARN_ABOVE:     warn_above_reg <= pwdata[0];
                REG_WARN_THRESHOLD: warn_threshold_reg <= pwdata;
                REG_ANTOINE_A:      antoine_a_reg <= pwdata;
                REG_ANTOINE_B:      antoine_b_reg <= pwdata;
                REG_ANTOINE_C:      antoine_c_reg <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_WARN_QUANTITY:  prdata = {29'd0, warn_quantity_reg};
            REG_WARN_ABOVE:     prdata = {31'd0, warn_above_reg};
            REG_WARN_THRESHOLD: prdata = warn_threshold_reg;
            REG_ANTOINE_A:      prdata = antoine_a_reg;
            REG_ANTOINE_B:      prdata = antoine_b_reg;
            REG_ANTOINE_C:      prdata = antoine_c_reg;
            default:            prdata = 32'd0;
        endcase
    end

    // Stage valid inputs
    always_comb
    begin
        stg_vin[0] = s_axis_tvalid;
        stg_vin[1] = stg_vld_reg[0];
        stg_vin[2] = stg_vld_reg[1];
        stg_vin[3] = d1_vld[DIV_STEPS];
        stg_vin[4] = stg_vld_reg[3];
        stg_vin[5] = stg_vld_reg[4];
        stg_vin[6] = stg_vld_reg[5];
        stg_vin[7] = ex_vld[EXP_STEPS];
        stg_vin[8] = lg_vld[LOG_STEPS];
        stg_vin[9] = stg_vld_reg[8];
        stg_vin[10] = stg_vld_reg[9];
        stg_vin[11] = stg_vld_reg[10];
        stg_vin[12] = d2_vld[DIV_STEPS];
        stg_vin[13] = stg_vld_reg[12];
        stg_vin[14] = stg_vld_reg[13];
    end

    always_comb
    begin
        // Sensor codes to temperature product and humidity
        st_c = {s_axis_tdata[15:2], 2'b00};
        sh_c = {s_axis_tdata[31:18], 2'b00};
        stg_next[0] = '0;
        stg_next[0].qty = s_axis_tuser;
        stg_next[0].tprod = 56'(K_TGAIN) * 56'(st_c);
        stg_next[0].rh = $signed({9'd0, sh_c}) * 25'sd125 - 25'sd393216;

        stg_next[1] = stg_reg[0];
        tsum = $signed({8'd0, stg_reg[0].tprod}) + T_BIAS;
        stg_next[1].t = tsum[56:32];

        // First divider setup: B / (T + C)
        stg_next[2] = stg_reg[1];
        dsum = $signed({{9{stg_reg[1].t[24]}}, stg_reg[1].t})
             + $signed({2'b00, antoine_c_reg});
        dmag = dsum[33] ? -dsum : dsum;
        stg_next[2].dinv = dsum == 34'sd0;
        stg_next[2].dneg = dsum[33];
        stg_next[2].dvs = {16'd0, dmag};
        stg_next[2].pq = {antoine_b_reg, 16'd0};
        stg_next[2].rem = 50'd0;

        stg_next[3] = d1_item[DIV_STEPS];
        stg_next[3].q = d1_item[DIV_STEPS].dneg ? -$signed({1'b0, d1_item[DIV_STEPS].pq})
                                                :  $signed({1'b0, d1_item[DIV_STEPS].pq});

        stg_next[4] = stg_reg[3];
        ediff = $signed({19'd0, antoine_a_reg}) - {{2{stg_reg[3].q[48]}}, stg_reg[3].q};
        priority if (ediff > E_LIM)
        begin
            stg_next[4].e = E_LIM[23:0];
        end
        else if (ediff < -E_LIM)
        begin
            stg_next[4].e = -E_LIM[23:0];
        end
        else
        begin
            stg_next[4].e = ediff[23:0];
        end

        stg_next[5] = stg_reg[4];
        ywide = stg_reg[4].e * $signed({1'b0, K_LOG2_10});
        stg_next[5].y = ywide[55:0];

        stg_next[6] = stg_reg[5];
        stg_next[6].n = stg_reg[5].y[55:46];
        stg_next[6].ef = stg_reg[5].y[45:16];
        stg_next[6].acc = 32'h4000_0000;

        // Pressure scaling and logarithm setup
        stg_next[7] = ex_item[EXP_STEPS];
        sexp = {ex_item[EXP_STEPS].n[9], ex_item[EXP_STEPS].n} - 11'sd14;
        rsh = 6'(-sexp);
        lsh = {2'b00, ex_item[EXP_STEPS].acc} << sexp[0];
        rsum = ({9'd0, ex_item[EXP_STEPS].acc} + (41'd1 << (rsh - 6'd1))) >> rsh;
        priority if (sexp >= 11'sd2)
        begin
            stg_next[7].pp = V_MAX;
        end
        else if (sexp >= 11'sd0)
        begin
            stg_next[7].pp = (lsh > 34'h0_7FFF_FFFF) ? V_MAX : lsh[31:0];
        end
        else if (sexp < -11'sd40)
        begin
            stg_next[7].pp = 32'sd0;
        end
        else
        begin
            stg_next[7].pp = rsum[31:0];
        end
        stg_next[7].lp = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (ex_item[EXP_STEPS].rh[i])
            begin
                stg_next[7].lp = 5'(i);
            end
        end
        stg_next[7].lm = {9'd0, ex_item[EXP_STEPS].rh[22:0]} << (5'd30 - stg_next[7].lp);
        stg_next[7].lf = 30'd0;

        stg_next[8] = lg_item[LOG_STEPS];
        l2 = {6'(lg_item[LOG_STEPS].lp) - 6'd16, lg_item[LOG_STEPS].lf};
        stg_next[8].lprod = l2 * K_LOG10_2;

        stg_next[9] = stg_reg[8];
        lsum = stg_reg[8].lprod + (64'sd1 <<< 41);
        stg_next[9].logv = lsum[63:42];

        stg_next[10] = stg_reg[9];
        stg_next[10].den = {{29{stg_reg[9].logv[21]}}, stg_reg[9].logv} - 51'sd131072
                         - {{2{stg_reg[9].q[48]}}, stg_reg[9].q};

        // Second divider setup: B / (log10(RH) - 2 - q)
        stg_next[11] = stg_reg[10];
        dmag2 = stg_reg[10].den[50] ? -stg_reg[10].den : stg_reg[10].den;
        stg_next[11].den0 = stg_reg[10].den == 51'sd0;
        stg_next[11].dneg = stg_reg[10].den[50];
        stg_next[11].dvs = dmag2[49:0];
        stg_next[11].pq = {antoine_b_reg, 16'd0};
        stg_next[11].rem = 50'd0;

        stg_next[12] = d2_item[DIV_STEPS];
        stg_next[12].q = d2_item[DIV_STEPS].dneg ? -$signed({1'b0, d2_item[DIV_STEPS].pq})
                                                 :  $signed({1'b0, d2_item[DIV_STEPS].pq});

        stg_next[13] = stg_reg[12];
        stg_next[13].t2 = {stg_reg[12].q[48], stg_reg[12].q} + $signed({18'd0, antoine_c_reg});

        // Result selection
        stg_next[14] = stg_reg[13];
        ndew = -{stg_reg[13].t2[49], stg_reg[13].t2};
        stg_next[14].inv = (stg_reg[13].qty[1] && stg_reg[13].dinv)
                         || (stg_reg[13].qty == QTY_DEW
                             && (stg_reg[13].rh <= 25'sd0 || stg_reg[13].den0));
        unique case (stg_reg[13].qty)
            QTY_TEMP:
            begin
                stg_next[14].value = 32'(stg_reg[13].t);
            end
            QTY_HUMIDITY:
            begin
                stg_next[14].value = 32'(stg_reg[13].rh);
            end
            QTY_PRESSURE:
            begin
                stg_next[14].value = stg_next[14].inv ? 32'sd0 : stg_reg[13].pp;
            end
            QTY_DEW:
            begin
                priority if (stg_next[14].inv)
                begin
                    stg_next[14].value = 32'sd0;
                end
                else if (ndew > 51'(V_MAX))
                begin
                    stg_next[14].value = V_MAX;
                end
                else if (ndew < 51'(V_MIN))
                begin
                    stg_next[14].value = V_MIN;
                end
                else
                begin
                    stg_next[14].value = ndew[31:0];
                end
            end
            default:
            begin
                stg_next[14].value = 32'sd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= 15'd0;
        end
        else if (en)
        begin
            stg_vld_reg <= stg_vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

    assign d1_item[0] = stg_reg[2];
    assign d1_vld[0] = stg_vld_reg[2];
    assign ex_item[0] = stg_reg[6];
    assign ex_vld[0] = stg_vld_reg[6];
    assign lg_item[0] = stg_reg[7];
    assign lg_vld[0] = stg_vld_reg[7];
    assign d2_item[0] = stg_reg[11];
    assign d2_vld[0] = stg_vld_reg[11];

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div1
        dpt_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (d1_vld[g]),
            .in_item   (d1_item[g]),
            .out_valid (d1_vld[g + 1]),
            .out_item  (d1_item[g + 1])
        );
    end

    for (genvar g = 0; g < EXP_STEPS; g++)
    begin : g_exp
        dpt_exp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .root      (EXP_ROOT[g]),
            .in_valid  (ex_vld[g]),
            .in_item   (ex_item[g]),
            .out_valid (ex_vld[g + 1]),
            .out_item  (ex_item[g + 1])
        );
    end

    for (genvar g = 0; g < LOG_STEPS; g++)
    begin : g_log
        dpt_log_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (lg_vld[g]),
            .in_item   (lg_item[g]),
            .out_valid (lg_vld[g + 1]),
            .out_item  (lg_item[g + 1])
        );
    end

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div2
        dpt_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (d2_vld[g]),
            .in_item   (d2_item[g]),
            .out_valid (d2_vld[g + 1]),
            .out_item  (d2_item[g + 1])
        );
    end

    // Output register with threshold test
    always_comb
    begin
        alarm_next = 1'b0;
        if (({1'b0, stg_reg[14].qty} + 3'd1) == warn_quantity_reg)
        begin
            alarm_next = warn_above_reg ? (stg_reg[14].value > warn_threshold_reg)
                                        : (stg_reg[14].value < warn_threshold_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= stg_vld_reg[14];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_value_reg <= stg_reg[14].value;
            out_alarm_reg <= alarm_next;
            out_inv_reg <= stg_reg[14].inv;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_value_reg;
    assign m_axis_tuser = {out_inv_reg, out_alarm_reg};

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("Input accepted while the output is stalled.");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == 32'd0))
        else $error("Invalid result carries a nonzero value.");

    a_no_alarm_unarmed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && warn_quantity_reg == 3'd0) |-> !m_axis_tuser[0])
        else $error("Alarm raised while no quantity is selected for warning.");

endmodule

`default_nettype wire

// ===== src/dpt_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dpt_div_cell
    import dpt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    logic [50:0] shifted;
    logic [50:0] diff;
    logic        ge;
    item_t       item_next;
    item_t       item_reg;
    logic        valid_reg;

    always_comb
    begin
        shifted = {in_item.rem, in_item.pq[47]};
        diff = shifted - {1'b0, in_item.dvs};
        ge = shifted >= {1'b0, in_item.dvs};
        item_next = in_item;
        item_next.rem = ge ? diff[49:0] : shifted[49:0];
        item_next.pq = {in_item.pq[46:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item = item_reg;

endmodule

`default_nettype wire

// ===== src/dpt_exp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dpt_exp_cell
    import dpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [31:0] root,
    input  logic        in_valid,
    input  item_t       in_item,
    output logic        out_valid,
    output item_t       out_item
);

    logic [63:0] prod;
    item_t       item_next;
    item_t       item_reg;
    logic        valid_reg;

    always_comb
    begin
        prod = {32'd0, in_item.acc} * {32'd0, root} + (64'd1 << 29);
        item_next = in_item;
        if (in_item.ef[29])
        begin
            item_next.acc = prod[61:30];
        end
        item_next.ef = {in_item.ef[28:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item = item_reg;

endmodule

`default_nettype wire

// ===== src/dpt_log_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dpt_log_cell
    import dpt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    logic [63:0] sq;
    logic [31:0] m2;
    item_t       item_next;
    item_t       item_reg;
    logic        valid_reg;

    always_comb
    begin
        sq = {32'd0, in_item.lm} * {32'd0, in_item.lm};
        m2 = sq[61:30];
        item_next = in_item;
        item_next.lm = m2[31] ? {1'b0, m2[31:1]} : m2;
        item_next.lf = {in_item.lf[28:0], m2[31]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item = item_reg;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import dpt_pkg::*;

    class dew_point_scoreboard;
        bit [2:0]   warn_qty;
        bit         warn_above;
        longint     warn_thr;
        longint     coef_a;
        longint     coef_b;
        longint     coef_c;
        bit [33:0]  pending[$];
        int         errors;

        function new();
            warn_qty = 0;
            warn_above = 0;
            warn_thr = 0;
            coef_a = 533017;
            coef_b = 115499991;
            coef_c = 15444214;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_WARN_QUANTITY:  warn_qty = val[2:0];
                REG_WARN_ABOVE:     warn_above = val[0];
                REG_WARN_THRESHOLD: warn_thr = longint'(signed'(val));
                REG_ANTOINE_A:      coef_a = longint'(val);
                REG_ANTOINE_B:      coef_b = longint'(val);
                REG_ANTOINE_C:      coef_c = longint'(val);
                default:            ;
            endcase
        endfunction

        function longint round_shift(longint v, int n);
            longint r;
            r = (v + (longint'(1) <<< (n - 1))) >>> n;
            return r;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint celsius(bit [15:0] raw);
            longint s;
            s = longint'(raw & 16'hFFFC);
            return round_shift(64'sd754711653253 * s - 64'sd201219217818 * 65536, 32);
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint unsigned pow2_fraction(longint unsigned f);
            longint unsigned acc;
            longint unsigned t;
            acc = 64'd1 << 30;
            t = 64'd1 << 31;
            for (int k = 1; k <= 30; k++)
            begin
                t = int_sqrt(t << 30);
                if ((f >> (30 - k)) & 1)
                    acc = (acc * t + (64'd1 << 29)) >> 30;
            end
            return acc;
        endfunction

        function longint pow10(longint e);
            longint y;
            longint n;
            longint s;
            longint unsigned mant;
            if (e > (64'sd64 <<< 16))
                e = 64'sd64 <<< 16;
            if (e < -(64'sd64 <<< 16))
                e = -(64'sd64 <<< 16);
            y = e * 64'sd3566893132;
            n = y >>> 46;
            mant = pow2_fraction((longint'(unsigned'(y)) & ((64'd1 << 46) - 1)) >> 16);
            s = n + 16 - 30;
            if (s >= 2)
                return 64'sd2147483647;
            if (s >= 0)
                return clip32(longint'(mant << s));
            if (s < -40)
                return 0;
            return longint'((mant + (64'd1 << (-s - 1))) >> (-s));
        endfunction

        function longint log10(longint unsigned v);
            int p;
            longint unsigned m;
            longint frac;
            longint l2;
            p = 63;
            frac = 0;
            while (!v[p])
                p--;
            m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
            for (int i = 1; i <= 30; i++)
            begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31))
                begin
                    m = m >> 1;
                    frac = frac | (longint'(1) <<< (30 - i));
                end
            end
            l2 = longint'(p - 16) * (64'sd1 <<< 30) + frac;
            return round_shift(l2 * 64'sd80807124, 42);
        endfunction

        function void note(bit [15:0] raw_t, bit [15:0] raw_h, bit [1:0] qty);
            longint t;
            longint rh;
            longint d;
            longint q;
            longint den;
            longint val;
            bit     inv;
            bit     alarm;
            t = celsius(raw_t);
            rh = round_shift((64'sd125 * longint'(raw_h & 16'hFFFC) - 64'sd393216)
                             * (64'sd1 <<< 32), 32);
            d = t + coef_c;
            q = 0;
            val = 0;
            inv = 0;
            alarm = 0;
            if (qty >= QTY_PRESSURE)
            begin
                if (d == 0)
                    inv = 1;
                else
                    q = (coef_b <<< 16) / d;
            end
            case (qty)
                QTY_TEMP:     val = clip32(t);
                QTY_HUMIDITY: val = clip32(rh);
                QTY_PRESSURE:
                begin
                    if (!inv)
                        val = pow10(coef_a - q);
                end
                default:
                begin
                    if (!inv && rh <= 0)
                        inv = 1;
                    if (!inv)
                    begin
                        den = log10(longint'(rh)) - (64'sd2 <<< 16) - q;
                        if (den == 0)
                            inv = 1;
                        else
                            val = clip32(-((coef_b <<< 16) / den + coef_c));
                    end
                end
            endcase
            if (warn_qty == {1'b0, qty} + 3'd1)
                alarm = warn_above ? (val > warn_thr) : (val < warn_thr);
            pending.push_back({inv, alarm, val[31:0]});
        endfunction

        function void check(bit [31:0] value, bit alarm, bit inv);
            bit [33:0] want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result value=%h alarm=%b invalid=%b",
                         $time, value, alarm, inv);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want[31:0] !== value)
            begin
                $display("%0t: value expected %h actual %h", $time, want[31:0], value);
                errors++;
            end
            if (want[32] !== alarm)
            begin
                $display("%0t: alarm expected %b actual %b", $time, want[32], alarm);
                errors++;
            end
            if (want[33] !== inv)
            begin
                $display("%0t: invalid expected %b actual %b", $time, want[33], inv);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dew_point_scoreboard sb;
    int unsigned         cycle_count;

    humidity_sensor_dew_point_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("humidity_sensor_dew_point_top verification failed");
        $finish;
    end

    // Neither side idles while cycle_count lies in the no-break window; elsewhere breaks are random.
    function automatic bit take_break();
        if (cycle_count >= 1000 && cycle_count < 2000)
            return 0;
        return $urandom_range(99) < 11;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= !take_break();
    end

    task automatic send(bit [15:0] raw_t, bit [15:0] raw_h, bit [1:0] qty);
        if (take_break())
        begin
            s_axis_tvalid = 0;
            @(negedge clk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata = {raw_h, raw_t};
        s_axis_tuser = qty;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel = 1;
        pwrite = 1;
        penable = 0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
        sb.write_reg(idx, val);
    endtask

    task automatic random_items(int count);
        bit [15:0] raw_t;
        bit [15:0] raw_h;
        for (int i = 0; i < count; i++)
        begin
            raw_t = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(15000, 30000));
            raw_h = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4000, 60000));
            send(raw_t, raw_h, 2'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        cycle_count = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = 0;
        m_axis_tready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        write_reg(REG_WARN_QUANTITY, 32'd4);
        write_reg(REG_WARN_ABOVE, 32'd0);
        write_reg(REG_WARN_THRESHOLD, 32'd5 << 16);
        for (int qv = 0; qv < 4; qv++)
        begin
            send(16'h0000, 16'h0000, 2'(qv));
            send(16'hFFFF, 16'hFFFF, 2'(qv));
            send(16'h6666, 16'h8000, 2'(qv));
            send(16'h4000, 16'h0C4A, 2'(qv));
        end
        random_items(60);
        drain();

        // Temperature code 0 with C equal to minus its Celsius value makes T + C zero.
        write_reg(REG_ANTOINE_C, 32'(-sb.celsius(16'h0000)));
        write_reg(REG_WARN_QUANTITY, 32'd3);
        write_reg(REG_WARN_ABOVE, 32'd1);
        write_reg(REG_WARN_THRESHOLD, 32'h8000_0000);
        send(16'h0003, 16'h8000, QTY_PRESSURE);
        send(16'h0000, 16'h8000, QTY_DEW);
        send(16'h0001, 16'h8000, QTY_TEMP);
        random_items(60);
        drain();

        write_reg(REG_ANTOINE_A, 32'hFFFF_FFFF);
        write_reg(REG_ANTOINE_B, 32'h0000_0000);
        write_reg(REG_ANTOINE_C, 32'hFFFF_FFFF);
        write_reg(REG_WARN_QUANTITY, 32'd1);
        write_reg(REG_WARN_THRESHOLD, 32'h7FFF_FFFF);
        random_items(60);
        drain();

        write_reg(REG_ANTOINE_A, 32'h0000_0000);
        write_reg(REG_ANTOINE_B, 32'hFFFF_FFFF);
        write_reg(REG_ANTOINE_C, 32'h0000_0001);
        write_reg(REG_WARN_QUANTITY, 32'd2);
        write_reg(REG_WARN_ABOVE, 32'd0);
        write_reg(REG_WARN_THRESHOLD, 32'h0032_0000);
        random_items(60);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_ANTOINE_A, 32'd533017 + $urandom_range(0, 200000) - 100000);
            write_reg(REG_ANTOINE_B, 32'd115499991 + $urandom_range(0, 20000000) - 10000000);
            write_reg(REG_ANTOINE_C, $urandom_range(3) == 0 ? $urandom : 32'd15444214);
            write_reg(REG_WARN_QUANTITY, $urandom_range(7));
            write_reg(REG_WARN_ABOVE, $urandom_range(1));
            write_reg(REG_WARN_THRESHOLD, $urandom_range(1) ? $urandom
                                                            : $urandom_range(0, 32'h0064_0000));
            random_items(50);
            drain();
        end

        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("humidity_sensor_dew_point_top verification clean");
        else
            $display("humidity_sensor_dew_point_top verification failed");
        $finish;
    end
endmodule
